>>> src/lap3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lap3_pkg
// Shared types and constants for the 3x3 Laplacian stream filter.
// ----------------------------------------------------------------------------
package lap3_pkg;

  localparam int MaxWidth   = 4096;
  localparam int AddrW      = $clog2(MaxWidth);
  localparam int PixW       = 8;
  localparam int CoordW     = 12;
  localparam int DimW       = 13;
  localparam int CfgIndexW  = 8;

  localparam logic [DimW-1:0] DimMin       = DimW'(3);
  localparam logic [DimW-1:0] HeightMax    = DimW'(4096);
  localparam logic [DimW-1:0] WidthMax     = (MaxWidth < 4096) ? DimW'(MaxWidth) : DimW'(4096);
  localparam logic [DimW-1:0] WidthReset   = DimW'(640);
  localparam logic [DimW-1:0] HeightReset  = DimW'(480);

  localparam logic [CfgIndexW-1:0] RegImageWidth  = CfgIndexW'(0);
  localparam logic [CfgIndexW-1:0] RegImageHeight = CfgIndexW'(1);

  typedef struct packed {
    logic [PixW-1:0]   pix;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic              produce;
    logic              last;
  } stage_t;

endpackage

>>> src/lap3_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lap3_line_store
// Two row memories with registered read data and one write port each.
// ----------------------------------------------------------------------------
module lap3_line_store (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [lap3_pkg::AddrW-1:0]   rd_addr,
  input  logic                         wr_en,
  input  logic [lap3_pkg::AddrW-1:0]   wr_addr,
  input  logic [lap3_pkg::PixW-1:0]    wr_upper,
  input  logic [lap3_pkg::PixW-1:0]    wr_middle,
  output logic [lap3_pkg::PixW-1:0]    rd_upper,
  output logic [lap3_pkg::PixW-1:0]    rd_middle
);

  logic [lap3_pkg::PixW-1:0] mem_upper  [lap3_pkg::MaxWidth];
  logic [lap3_pkg::PixW-1:0] mem_middle [lap3_pkg::MaxWidth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_upper[wr_addr] <= wr_upper;
    end
    if (rd_en) begin
      rd_upper <= mem_upper[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_middle[wr_addr] <= wr_middle;
    end
    if (rd_en) begin
      rd_middle <= mem_middle[rd_addr];
    end
  end

endmodule

>>> src/lap3_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lap3_window
// 3x3 pixel window with the Laplacian kernel sum and clamp.
// ----------------------------------------------------------------------------
module lap3_window (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       shift_en,
  input  logic [lap3_pkg::PixW-1:0]  new_upper,
  input  logic [lap3_pkg::PixW-1:0]  new_middle,
  input  logic [lap3_pkg::PixW-1:0]  new_lower,
  output logic [lap3_pkg::PixW-1:0]  filt_value
);

  logic [lap3_pkg::PixW-1:0] win      [9];
  logic [lap3_pkg::PixW-1:0] win_next [9];
  logic [11:0]               ring_sum;
  logic signed [13:0]        total;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r*3]     = win[r*3+1];
      win_next[r*3+1]   = win[r*3+2];
    end
    win_next[2] = new_upper;
    win_next[5] = new_middle;
    win_next[8] = new_lower;
  end

  always_comb begin
    ring_sum = 12'(win_next[0]) + 12'(win_next[1]) + 12'(win_next[2])
             + 12'(win_next[3]) + 12'(win_next[5]) + 12'(win_next[6])
             + 12'(win_next[7]) + 12'(win_next[8]);
    total = $signed({2'b00, ring_sum}) - $signed({3'b000, win_next[4], 3'b000});
    if (total < 0) begin
      filt_value = '0;
    end else if (total > 14'sd255) begin
      filt_value = '1;
    end else begin
      filt_value = total[lap3_pkg::PixW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++) begin
        win[k] <= '0;
      end
    end else if (shift_en) begin
      for (int k = 0; k < 9; k++) begin
        win[k] <= win_next[k];
      end
    end
  end

endmodule

>>> src/laplacian_3x3_stream_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laplacian_3x3_stream_filter
// Streaming 3x3 Laplacian filter over raster-order 8-bit pixels.
// A pixel is held in stage s1; the result register loads when s1 advances.
// Throughput: one pixel per cycle while out_ready is high; a stalled result
// holds one more pixel and then stops input.
// Reset clears the counters, window and pipeline and loads width 640 and
// height 480; line memory contents stay undefined until written.
// ----------------------------------------------------------------------------
module laplacian_3x3_stream_filter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lap3_pkg::PixW-1:0]         pixel_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lap3_pkg::PixW-1:0]         filtered_value,
  output logic [lap3_pkg::CoordW-1:0]       center_column,
  output logic [lap3_pkg::CoordW-1:0]       center_row,
  output logic                              frame_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lap3_pkg::CfgIndexW-1:0]    cfg_index,
  input  logic [lap3_pkg::DimW-1:0]         cfg_data
);

  logic [lap3_pkg::DimW-1:0]   image_width;
  logic [lap3_pkg::DimW-1:0]   image_height;
  logic [lap3_pkg::DimW-1:0]   w_eff;
  logic [lap3_pkg::DimW-1:0]   h_eff;
  logic [lap3_pkg::CoordW-1:0] col;
  logic [lap3_pkg::CoordW-1:0] row;
  logic                        col_end;
  logic                        row_end;
  logic                        in_fire;
  logic                        cfg_fire;
  logic                        adv;
  logic                        s1_valid;
  lap3_pkg::stage_t            s1;
  lap3_pkg::stage_t            s1_next;
  logic [lap3_pkg::PixW-1:0]   rd_upper;
  logic [lap3_pkg::PixW-1:0]   rd_middle;
  logic [lap3_pkg::PixW-1:0]   filt_value;

  always_comb begin
    w_eff = image_width;
    if (w_eff < lap3_pkg::DimMin) begin
      w_eff = lap3_pkg::DimMin;
    end else if (w_eff > lap3_pkg::WidthMax) begin
      w_eff = lap3_pkg::WidthMax;
    end
    h_eff = image_height;
    if (h_eff < lap3_pkg::DimMin) begin
      h_eff = lap3_pkg::DimMin;
    end else if (h_eff > lap3_pkg::HeightMax) begin
      h_eff = lap3_pkg::HeightMax;
    end
  end

  assign col_end   = ({1'b0, col} + 13'd1) >= w_eff;
  assign row_end   = ({1'b0, row} + 13'd1) >= h_eff;
  assign cfg_ready = !rst;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign adv       = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !rst && (!s1_valid || adv);
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    s1_next.pix     = pixel_value;
    s1_next.col     = col;
    s1_next.row     = row;
    s1_next.produce = (col >= 12'd2) && (row >= 12'd2);
    s1_next.last    = col_end && row_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= lap3_pkg::WidthReset;
      image_height <= lap3_pkg::HeightReset;
      col          <= '0;
      row          <= '0;
    end else if (cfg_fire) begin
      if (cfg_index == lap3_pkg::RegImageWidth) begin
        image_width <= cfg_data;
        col         <= '0;
        row         <= '0;
      end else if (cfg_index == lap3_pkg::RegImageHeight) begin
        image_height <= cfg_data;
        col          <= '0;
        row          <= '0;
      end
    end else if (in_fire) begin
      if (col_end) begin
        col <= '0;
        row <= row_end ? '0 : row + 12'd1;
      end else begin
        col <= col + 12'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
    if (in_fire) begin
      s1 <= s1_next;
    end
  end

  lap3_line_store u_line_store (
    .clk       (clk),
    .rd_en     (in_fire),
    .rd_addr   (col[lap3_pkg::AddrW-1:0]),
    .wr_en     (adv),
    .wr_addr   (s1.col[lap3_pkg::AddrW-1:0]),
    .wr_upper  (rd_middle),
    .wr_middle (s1.pix),
    .rd_upper  (rd_upper),
    .rd_middle (rd_middle)
  );

  lap3_window u_window (
    .clk        (clk),
    .rst        (rst),
    .shift_en   (adv),
    .new_upper  (rd_upper),
    .new_middle (rd_middle),
    .new_lower  (s1.pix),
    .filt_value (filt_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && s1.produce) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (adv && s1.produce) begin
      filtered_value <= filt_value;
      center_column  <= s1.col - 12'd1;
      center_row     <= s1.row - 12'd1;
      frame_last     <= s1.last;
    end
  end

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("output valid right after reset");

  a_interior_only: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (center_column != '0) && (center_row != '0))
    else $error("result for a border pixel");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !adv) |=> s1_valid) else $error("pending pixel dropped");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("pixel accepted while pipeline is blocked");

endmodule

>>> verif/laplacian_3x3_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laplacian_3x3_checker
// Watches the pixel, result and register channels of the Laplacian stream
// filter. It keeps its own copy of the line stores, the 3x3 window, the
// frame counters and the image size. It predicts the result of each
// accepted pixel from column 2, row 2 on, and compares each result
// transaction in order, field by field, with the oldest waiting prediction.
// ----------------------------------------------------------------------------
module laplacian_3x3_checker (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  input  logic                                     in_ready,
  input  logic [lap3_pkg::PixW-1:0]                pixel_value,
  input  logic                                     out_valid,
  input  logic                                     out_ready,
  input  logic [lap3_pkg::PixW-1:0]                filtered_value,
  input  logic [lap3_pkg::CoordW-1:0]              center_column,
  input  logic [lap3_pkg::CoordW-1:0]              center_row,
  input  logic                                     frame_last,
  input  logic                                     cfg_valid,
  input  logic                                     cfg_ready,
  input  logic [lap3_pkg::CfgIndexW-1:0]           cfg_index,
  input  logic [lap3_pkg::DimW-1:0]                cfg_data,
  output int                                       failures,
  output int                                       results_outstanding
);

  typedef struct packed {
    logic [lap3_pkg::PixW-1:0]   value;
    logic [lap3_pkg::CoordW-1:0] column;
    logic [lap3_pkg::CoordW-1:0] row;
    logic                        last;
  } laplacian_t;

  logic [lap3_pkg::PixW-1:0] upper_line [lap3_pkg::MaxWidth];
  logic [lap3_pkg::PixW-1:0] middle_line [lap3_pkg::MaxWidth];
  logic [lap3_pkg::PixW-1:0] window [9];
  int unsigned               col_pos;
  int unsigned               row_pos;
  logic [lap3_pkg::DimW-1:0] width_setting;
  logic [lap3_pkg::DimW-1:0] height_setting;
  laplacian_t                awaited_laplacians [$];
  int                        mismatches = 0;

  initial begin
    failures = 0;
    results_outstanding = 0;
  end

  function automatic int unsigned dim_clamp(input logic [lap3_pkg::DimW-1:0] raw,
                                            input logic [lap3_pkg::DimW-1:0] top);
    if (raw < lap3_pkg::DimMin) return 32'(lap3_pkg::DimMin);
    if (raw > top) return 32'(top);
    return 32'(raw);
  endfunction

  task automatic predict_laplacian(input logic [lap3_pkg::PixW-1:0] pix);
    int unsigned                w;
    int unsigned                h;
    logic [lap3_pkg::AddrW-1:0] slot;
    int                         acc;
    int                         k;
    laplacian_t                 res;
    w = dim_clamp(width_setting, lap3_pkg::WidthMax);
    h = dim_clamp(height_setting, lap3_pkg::HeightMax);
    slot = col_pos[lap3_pkg::AddrW-1:0];
    for (k = 0; k < 3; k++) begin
      window[3 * k] = window[3 * k + 1];
      window[3 * k + 1] = window[3 * k + 2];
    end
    window[2] = upper_line[slot];
    window[5] = middle_line[slot];
    window[8] = pix;
    upper_line[slot] = middle_line[slot];
    middle_line[slot] = pix;
    if (col_pos >= 2 && row_pos >= 2) begin
      acc = 0;
      for (k = 0; k < 9; k++) begin
        if (k == 4) begin
          acc = acc - 8 * int'(window[k]);
        end else begin
          acc = acc + int'(window[k]);
        end
      end
      if (acc < 0) acc = 0;
      if (acc > 255) acc = 255;
      res.value = lap3_pkg::PixW'(acc);
      res.column = lap3_pkg::CoordW'(col_pos - 1);
      res.row = lap3_pkg::CoordW'(row_pos - 1);
      res.last = (col_pos + 1 >= w) && (row_pos + 1 >= h);
      awaited_laplacians = {awaited_laplacians, res};
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    laplacian_t want;
    int         k;
    if (rst) begin
      awaited_laplacians.delete();
      for (k = 0; k < lap3_pkg::MaxWidth; k++) begin
        upper_line[k] = '0;
        middle_line[k] = '0;
      end
      for (k = 0; k < 9; k++) window[k] = '0;
      col_pos = 0;
      row_pos = 0;
      width_setting = lap3_pkg::WidthReset;
      height_setting = lap3_pkg::HeightReset;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_laplacians.size() == 0) begin
          $error("unexpected result transaction: filtered_value %0d, column %0d, row %0d",
                 filtered_value, center_column, center_row);
          mismatches++;
        end else begin
          want = awaited_laplacians.pop_front();
          compare_field("filtered_value", 32'(want.value), 32'(filtered_value));
          compare_field("center_column", 32'(want.column), 32'(center_column));
          compare_field("center_row", 32'(want.row), 32'(center_row));
          compare_field("frame_last", 32'(want.last), 32'(frame_last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == lap3_pkg::RegImageWidth) begin
          width_setting = cfg_data;
          col_pos = 0;
          row_pos = 0;
        end else if (cfg_index == lap3_pkg::RegImageHeight) begin
          height_setting = cfg_data;
          col_pos = 0;
          row_pos = 0;
        end
      end
      if (in_valid && in_ready) predict_laplacian(pixel_value);
    end
    failures <= mismatches;
    results_outstanding <= awaited_laplacians.size();
  end

endmodule

>>> verif/laplacian_3x3_stream_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laplacian_3x3_stream_filter_tb
// Drives the Laplacian stream filter with images of many sizes: one partial
// frame at the reset size, hand-built 3x3 frames that hit both clamps, and
// then random frames (mostly whole, sometimes cut short) with noisy, smooth
// or black-and-white content. The largest widths and heights close the run.
// The sender works in bursts and the receiver stalls in changing patterns.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module laplacian_3x3_stream_filter_tb;

  localparam int CycleLimit = 2_000_000;
  localparam int RandomPixels = 900;
  localparam int ResetPixels = 64;
  localparam int ClosingPixels = 64;
  localparam int TallPixels = 240;
  localparam int SettleCycles = 8;
  localparam logic [lap3_pkg::CfgIndexW-1:0] RegUnmapped = {lap3_pkg::CfgIndexW{1'b1}};

  typedef enum int {NoiseImage, SmoothImage, BinaryImage} image_style_t;
  typedef enum int {AlwaysReady, MostlyReady, PeriodicStall, HeavyStall} ready_pattern_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [lap3_pkg::PixW-1:0]      pixel_value = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [lap3_pkg::PixW-1:0]      filtered_value;
  logic [lap3_pkg::CoordW-1:0]    center_column;
  logic [lap3_pkg::CoordW-1:0]    center_row;
  logic                           frame_last;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [lap3_pkg::CfgIndexW-1:0] cfg_index = '0;
  logic [lap3_pkg::DimW-1:0]      cfg_data = '0;

  int             failures;
  int             results_outstanding;
  int             cycle_count = 0;
  int             burst_left = 0;
  bit             steady = 1'b0;
  int unsigned    frame_w = 32'(lap3_pkg::WidthReset);
  int unsigned    frame_h = 32'(lap3_pkg::HeightReset);
  ready_pattern_t ready_mode = AlwaysReady;
  int             mode_left = 0;

  always #10 clk = ~clk;

  laplacian_3x3_stream_filter dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .pixel_value    (pixel_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .filtered_value (filtered_value),
    .center_column  (center_column),
    .center_row     (center_row),
    .frame_last     (frame_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  laplacian_3x3_checker laplacian_check (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .pixel_value         (pixel_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .filtered_value      (filtered_value),
    .center_column       (center_column),
    .center_row          (center_row),
    .frame_last          (frame_last),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .failures            (failures),
    .results_outstanding (results_outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= ready_pattern_t'($urandom_range(0, 3));
      mode_left <= $urandom_range(32, 400);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      AlwaysReady:   out_ready <= 1'b1;
      MostlyReady:   out_ready <= ($urandom_range(0, 3) != 0);
      PeriodicStall: out_ready <= (mode_left % 8 > 2);
      default:       out_ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  function automatic int unsigned dim_limit(input logic [lap3_pkg::DimW-1:0] raw,
                                            input logic [lap3_pkg::DimW-1:0] top);
    if (raw < lap3_pkg::DimMin) return 32'(lap3_pkg::DimMin);
    if (raw > top) return 32'(top);
    return 32'(raw);
  endfunction

  function automatic logic [lap3_pkg::PixW-1:0] make_pixel(input image_style_t style,
                                                           input int base);
    case (style)
      NoiseImage:  return lap3_pkg::PixW'($urandom_range(0, 255));
      SmoothImage: return lap3_pkg::PixW'(base + int'($urandom_range(0, 16)) - 8);
      default:     return ($urandom_range(0, 1) != 0) ? {lap3_pkg::PixW{1'b1}} :
                                                        {lap3_pkg::PixW{1'b0}};
    endcase
  endfunction

  task automatic push_pixel(input logic [lap3_pkg::PixW-1:0] pix);
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    pixel_value <= pix;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  task automatic stream_pixels(input int count, input image_style_t style);
    int base;
    base = $urandom_range(8, 247);
    repeat (count) push_pixel(make_pixel(style, base));
  endtask

  task automatic wait_until_quiet();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (results_outstanding != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lap3_pkg::CfgIndexW-1:0] index,
                           input logic [lap3_pkg::DimW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [lap3_pkg::DimW-1:0] w_raw,
                           input logic [lap3_pkg::DimW-1:0] h_raw,
                           input bit write_w, input bit write_h, input bit stray);
    if (stray) begin
      write_reg(lap3_pkg::CfgIndexW'($urandom_range(lap3_pkg::RegImageHeight + 1,
                                                    RegUnmapped)),
                lap3_pkg::DimW'($urandom));
    end
    if (write_w) begin
      write_reg(lap3_pkg::RegImageWidth, w_raw);
      frame_w = dim_limit(w_raw, lap3_pkg::WidthMax);
    end
    if (write_h) begin
      write_reg(lap3_pkg::RegImageHeight, h_raw);
      frame_h = dim_limit(h_raw, lap3_pkg::HeightMax);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int                        i;
    int                        sel;
    int                        count;
    int                        random_pixels;
    logic [lap3_pkg::DimW-1:0] w_raw;
    logic [lap3_pkg::DimW-1:0] h_raw;
    image_style_t              style;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    stream_pixels(ResetPixels, NoiseImage);
    wait_until_quiet();

    configure(lap3_pkg::DimW'(2), lap3_pkg::DimW'(1), 1'b1, 1'b1, 1'b0);
    for (i = 0; i < 9; i++) push_pixel((i == 4) ? 8'd0 : 8'd255);
    for (i = 0; i < 9; i++) begin
      if (i == 4) begin
        wait_until_quiet();
        write_reg(RegUnmapped, {lap3_pkg::DimW{1'b1}});
        cfg_valid <= 1'b0;
      end
      push_pixel((i == 4) ? 8'd255 : 8'd0);
    end
    for (i = 0; i < 9; i++) push_pixel((i == 4) ? 8'd100 : 8'd128);
    wait_until_quiet();

    random_pixels = 0;
    while (random_pixels < RandomPixels) begin
      sel = $urandom_range(0, 5);
      w_raw = (sel == 0) ? lap3_pkg::DimW'($urandom_range(0, 2)) :
              (sel == 1) ? lap3_pkg::DimW'($urandom_range(13, 40)) :
                           lap3_pkg::DimW'($urandom_range(3, 12));
      sel = $urandom_range(0, 5);
      h_raw = (sel == 0) ? lap3_pkg::DimW'($urandom_range(0, 2)) :
              (sel == 1) ? lap3_pkg::DimW'($urandom_range(9, 16)) :
                           lap3_pkg::DimW'($urandom_range(3, 8));
      sel = $urandom_range(0, 7);
      configure(w_raw, h_raw, sel != 1 && sel != 2, sel != 0 && sel != 2,
                sel == 2 || sel == 7);
      steady = ($urandom_range(0, 3) == 0);
      style = image_style_t'($urandom_range(0, 2));
      count = frame_w * frame_h * $urandom_range(1, 3);
      if ($urandom_range(0, 4) == 0) count = $urandom_range(1, frame_w * frame_h - 1);
      stream_pixels(count, style);
      random_pixels += count;
      wait_until_quiet();
    end

    steady = 1'b0;
    configure({lap3_pkg::DimW{1'b1}}, lap3_pkg::DimW'(2), 1'b1, 1'b1, 1'b0);
    stream_pixels(ClosingPixels, NoiseImage);
    wait_until_quiet();

    steady = 1'b1;
    configure(lap3_pkg::DimMin, lap3_pkg::HeightMax, 1'b1, 1'b1, 1'b0);
    stream_pixels(TallPixels, SmoothImage);
    wait_until_quiet();

    steady = 1'b0;
    configure(lap3_pkg::WidthMax, lap3_pkg::DimW'(lap3_pkg::HeightMax + 1), 1'b1, 1'b1,
              1'b1);
    stream_pixels(ClosingPixels, SmoothImage);
    wait_until_quiet();

    repeat (SettleCycles) @(posedge clk);
    if (failures == 0 && results_outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
